### rtl/srrw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srrw_pkg
// Shared constants, types and codes of the selective-repeat receive window.
// ----------------------------------------------------------------------------
package srrw_pkg;

    // Window geometry; the slot count is a power of two so it divides the
    // 64-entry sequence space.
    localparam int WINDOW_SLOTS = 8;
    localparam int SLOT_BITS    = $clog2(WINDOW_SLOTS);

    // Field widths of one header word and one result word.
    localparam int SEQ_W  = 6;
    localparam int SIZE_W = 7;
    localparam int TAG_W  = 8;

    // Tag bits kept per parked packet.
    localparam int TAG_BITS      = 8;
    localparam int KEEP_TAG_BITS = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

    // Payload bytes are counted without the fixed header.
    localparam int HDR_BYTES = 4;

    // Result kinds.
    localparam logic KIND_ACK     = 1'b0;
    localparam logic KIND_DELIVER = 1'b1;

    typedef logic [SLOT_BITS-1:0] slot_t;

    typedef struct packed {
        logic [KEEP_TAG_BITS-1:0] tag;
        logic [SIZE_W-1:0]        size;
        logic                     head;
        logic                     tail;
    } entry_t;

    // Controller to datapath.
    typedef struct packed {
        logic capture;       // take a good header
        logic load_ack;      // emit acknowledgement, park if out of order
        logic deliver_cur;   // emit the just-received in-order packet
        logic deliver_walk;  // emit and release the parked packet at the walk slot
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic slot_filled;   // header slot already holds a parked packet
        logic slot_is_next;  // header slot is the expected slot
        logic walk_filled;   // walk slot holds a parked packet
        logic after_filled;  // slot after the walk slot holds a parked packet
        logic out_free;      // output register can take a word this cycle
    } status_t;

endpackage

`default_nettype wire

### rtl/srrw_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srrw_ctrl
// Sequencer: acknowledge, then deliver the in-order packet and walk the
// parked slots that follow it.
// ----------------------------------------------------------------------------
module srrw_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    input  wire logic             s_checksum_ok,
    output logic                  s_ready,
    input  wire srrw_pkg::status_t status,
    output srrw_pkg::cmd_t        cmd
);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_ACK     = 2'd1;
    localparam logic [1:0] ST_DELIVER = 2'd2;
    localparam logic [1:0] ST_WALK    = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                // drop bad headers silently
                if (s_valid && s_checksum_ok) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_ACK;
                end
            end
            ST_ACK: begin
                if (status.out_free) begin
                    cmd.load_ack = 1'b1;
                    if (!status.slot_filled && status.slot_is_next) begin
                        state_next = ST_DELIVER;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DELIVER: begin
                if (status.out_free) begin
                    cmd.deliver_cur = 1'b1;
                    state_next      = status.walk_filled ? ST_WALK : ST_IDLE;
                end
            end
            ST_WALK: begin
                if (status.out_free) begin
                    cmd.deliver_walk = 1'b1;
                    if (!status.after_filled) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### rtl/srrw_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srrw_datapath
// Header register, window slots, cursor, walk pointer and output register.
// ----------------------------------------------------------------------------
module srrw_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire srrw_pkg::cmd_t                cmd,
    output srrw_pkg::status_t                  status,
    input  wire logic [srrw_pkg::SEQ_W-1:0]    s_sequence_number,
    input  wire logic                          s_is_head,
    input  wire logic                          s_is_tail,
    input  wire logic [srrw_pkg::SIZE_W-1:0]   s_payload_size,
    input  wire logic [srrw_pkg::TAG_W-1:0]    s_payload_tag,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_kind,
    output logic [srrw_pkg::SEQ_W-1:0]         m_ack_number,
    output logic [srrw_pkg::TAG_W-1:0]         m_out_tag,
    output logic [srrw_pkg::SIZE_W-1:0]        m_out_size,
    output logic                               m_out_head,
    output logic                               m_out_tail,
    output logic                               m_last_result
);

    // captured header
    logic [srrw_pkg::SEQ_W-1:0] seq_reg;
    srrw_pkg::entry_t           cur_reg;

    // window
    logic [srrw_pkg::WINDOW_SLOTS-1:0] filled_reg;
    logic [srrw_pkg::WINDOW_SLOTS-1:0] filled_next;
    srrw_pkg::entry_t                  entry_reg [srrw_pkg::WINDOW_SLOTS];
    srrw_pkg::slot_t                   cursor_reg;
    srrw_pkg::slot_t                   cursor_next;
    srrw_pkg::slot_t                   walk_reg;
    srrw_pkg::slot_t                   walk_next;

    // output word
    logic                          m_valid_reg;
    logic                          m_valid_next;
    logic                          kind_reg;
    logic [srrw_pkg::SEQ_W-1:0]    ack_reg;
    srrw_pkg::entry_t              out_entry_reg;
    logic                          last_reg;

    srrw_pkg::slot_t  slot;
    srrw_pkg::slot_t  walk_plus;
    logic             park;
    logic             load_any;

    assign slot       = seq_reg[srrw_pkg::SLOT_BITS-1:0];
    assign walk_plus  = walk_reg + srrw_pkg::SLOT_BITS'(1);

    assign status.slot_filled  = filled_reg[slot];
    assign status.slot_is_next = (slot == cursor_reg);
    assign status.walk_filled  = filled_reg[walk_reg];
    assign status.after_filled = filled_reg[walk_plus];
    assign status.out_free     = !m_valid_reg || m_ready;

    assign park     = cmd.load_ack && !status.slot_filled && !status.slot_is_next;
    assign load_any = cmd.load_ack || cmd.deliver_cur || cmd.deliver_walk;

    always_comb begin
        filled_next  = filled_reg;
        cursor_next  = cursor_reg;
        walk_next    = walk_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (load_any) begin
            m_valid_next = 1'b1;
        end
        if (park) begin
            filled_next[slot] = 1'b1;
        end
        if (cmd.capture) begin
            walk_next = cursor_reg + srrw_pkg::SLOT_BITS'(1);
        end
        if (cmd.deliver_cur && !status.walk_filled) begin
            cursor_next = walk_reg;
        end
        if (cmd.deliver_walk) begin
            filled_next[walk_reg] = 1'b0;
            if (status.after_filled) begin
                walk_next = walk_plus;
            end else begin
                cursor_next = walk_plus;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filled_reg  <= '0;
            cursor_reg  <= '0;
            walk_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            filled_reg  <= filled_next;
            cursor_reg  <= cursor_next;
            walk_reg    <= walk_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            seq_reg      <= s_sequence_number;
            cur_reg.tag  <= s_payload_tag[srrw_pkg::KEEP_TAG_BITS-1:0];
            cur_reg.size <= s_payload_size;
            cur_reg.head <= s_is_head;
            cur_reg.tail <= s_is_tail;
        end
        if (park) begin
            entry_reg[slot] <= cur_reg;
        end
        if (cmd.load_ack) begin
            kind_reg      <= srrw_pkg::KIND_ACK;
            ack_reg       <= seq_reg;
            out_entry_reg <= '0;
            last_reg      <= status.slot_filled || !status.slot_is_next;
        end else if (cmd.deliver_cur) begin
            kind_reg      <= srrw_pkg::KIND_DELIVER;
            ack_reg       <= '0;
            out_entry_reg <= cur_reg;
            last_reg      <= !status.walk_filled;
        end else if (cmd.deliver_walk) begin
            kind_reg      <= srrw_pkg::KIND_DELIVER;
            ack_reg       <= '0;
            out_entry_reg <= entry_reg[walk_reg];
            last_reg      <= !status.after_filled;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = kind_reg;
    assign m_ack_number  = ack_reg;
    assign m_out_tag     = srrw_pkg::TAG_W'(out_entry_reg.tag);
    assign m_out_size    = out_entry_reg.size;
    assign m_out_head    = out_entry_reg.head;
    assign m_out_tail    = out_entry_reg.tail;
    assign m_last_result = last_reg;

    // the expected slot never holds a parked packet
    assert property (@(posedge aclk) disable iff (!aresetn)
        !filled_reg[cursor_reg])
        else $error("expected slot is marked filled");

    // only one action per cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.capture, cmd.load_ack, cmd.deliver_cur, cmd.deliver_walk}))
        else $error("more than one datapath command");

    // never overwrite a word that is still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        load_any |-> (!m_valid_reg || m_ready))
        else $error("output register overwritten");

    // the walk only releases parked packets
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.deliver_walk |-> filled_reg[walk_reg])
        else $error("walk delivered an empty slot");

endmodule

`default_nettype wire

### rtl/selective_repeat_receive_window.sv
`default_nettype none
// ----------------------------------------------------------------------------
// selective_repeat_receive_window
// Receive side of a selective-repeat ARQ link: acknowledges good headers,
// parks out-of-order packets and delivers packets in sequence order.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Word                                    Handshake
//  -------  ---------  --------------------------------------  ---------------
//  s_       in         checksum_ok, sequence_number, is_head,  s_valid/s_ready
//                      is_tail, payload_size, payload_tag
//  m_       out        kind, ack_number, out_tag, out_size,    m_valid/m_ready
//                      out_head, out_tail, last_result
//
// A header is taken only while the sequencer is idle; a bad-checksum header
// is dropped in the cycle it is taken. A good header is captured and then
// yields result words: an acknowledgement only, or also its delivery and
// the release of the run of parked packets behind it. The single output
// register moves one word per cycle while m_ready does not stall it.
// A stalled m_ready holds the sequencer in place; s_ready returns as soon as
// the last word is loaded, even if that word still waits to be taken.
// Synchronous reset clears the filled bits, cursor and valid; no clearing
// pass is needed since parked entries are only read behind their filled bit.
//
module selective_repeat_receive_window (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // header words
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_checksum_ok,
    input  wire logic [srrw_pkg::SEQ_W-1:0]    s_sequence_number,
    input  wire logic                          s_is_head,
    input  wire logic                          s_is_tail,
    input  wire logic [srrw_pkg::SIZE_W-1:0]   s_payload_size,
    input  wire logic [srrw_pkg::TAG_W-1:0]    s_payload_tag,
    // result words
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_kind,
    output logic [srrw_pkg::SEQ_W-1:0]         m_ack_number,
    output logic [srrw_pkg::TAG_W-1:0]         m_out_tag,
    output logic [srrw_pkg::SIZE_W-1:0]        m_out_size,
    output logic                               m_out_head,
    output logic                               m_out_tail,
    output logic                               m_last_result
);

    srrw_pkg::cmd_t    cmd;
    srrw_pkg::status_t status;

    // sequencer: acknowledge, deliver, walk the parked run
    srrw_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_checksum_ok (s_checksum_ok),
        .s_ready       (s_ready),
        .status        (status),
        .cmd           (cmd)
    );

    // window storage, cursor and output register
    srrw_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .s_sequence_number (s_sequence_number),
        .s_is_head         (s_is_head),
        .s_is_tail         (s_is_tail),
        .s_payload_size    (s_payload_size),
        .s_payload_tag     (s_payload_tag),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kind            (m_kind),
        .m_ack_number      (m_ack_number),
        .m_out_tag         (m_out_tag),
        .m_out_size        (m_out_size),
        .m_out_head        (m_out_head),
        .m_out_tail        (m_out_tail),
        .m_last_result     (m_last_result)
    );

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the selective-repeat receive window. Headers are
// driven over the s_ channel: a short directed run through the window
// corners, then random bursts of in-window sequence numbers in shuffled
// order, mixed with duplicates, bad checksums and stray numbers. A
// scoreboard predicts every acknowledgement and delivery word and checks
// each word taken from the m_ channel against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import srrw_pkg::*;

    localparam int RANDOM_HEADERS = 150;
    localparam int QUIET_TAIL     = 30;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int SETTLE_CYCLES  = 2 * (WINDOW_SLOTS + 2) + 4;

    // One result word as seen on the m_ channel.
    typedef struct packed {
        logic              kind;
        logic [SEQ_W-1:0]  ack;
        logic [TAG_W-1:0]  tag;
        logic [SIZE_W-1:0] size;
        logic              head;
        logic              tail;
        logic              last;
    } result_word_t;

    // Window predictor plus the queue of words still to come.
    class window_scoreboard;
        bit           filled [WINDOW_SLOTS];
        entry_t       parked [WINDOW_SLOTS];
        slot_t        cursor;
        result_word_t due_words [$];
        int           errors;

        function new();
            foreach (filled[i]) begin
                filled[i] = 1'b0;
                parked[i] = '0;
            end
            cursor = '0;
            errors = 0;
        endfunction

        function int pending();
            return due_words.size();
        endfunction

        // Append one predicted word behind the ones already due.
        function void enqueue_word(result_word_t w);
            due_words.insert(due_words.size(), w);
        endfunction

        function result_word_t delivery_word(entry_t e);
            result_word_t w;
            w      = '0;
            w.kind = KIND_DELIVER;
            w.tag  = TAG_W'(e.tag);
            w.size = e.size;
            w.head = e.head;
            w.tail = e.tail;
            return w;
        endfunction

        // Predict the words that one accepted header causes.
        function void note_header(logic ok, logic [SEQ_W-1:0] seq, logic head,
                                  logic tail, logic [SIZE_W-1:0] size,
                                  logic [TAG_W-1:0] tag);
            entry_t       cur;
            result_word_t w;
            slot_t        slot;
            slot_t        s;
            int           step;
            if (!ok)
                return;
            cur.tag  = tag[KEEP_TAG_BITS-1:0];
            cur.size = size;
            cur.head = head;
            cur.tail = tail;
            w      = '0;
            w.kind = KIND_ACK;
            w.ack  = seq;
            enqueue_word(w);
            slot = slot_t'(seq % WINDOW_SLOTS);
            if (filled[slot]) begin
                // duplicate: acknowledge only, keep the parked entry
            end else if (slot != cursor) begin
                parked[slot] = cur;
                filled[slot] = 1'b1;
            end else begin
                enqueue_word(delivery_word(cur));
                for (step = 1; step < WINDOW_SLOTS; step++) begin
                    s = slot_t'(cursor + step);
                    if (!filled[s])
                        break;
                    enqueue_word(delivery_word(parked[s]));
                    filled[s] = 1'b0;
                end
                cursor = slot_t'(cursor + step);
            end
            due_words[due_words.size() - 1].last = 1'b1;
        endfunction

        function void compare_field(string what, int want, int got);
            if (want != got) begin
                errors++;
                $display("%0t: mismatch on %s: expected %0d, actual %0d",
                         $time, what, want, got);
            end
        endfunction

        function void check_word(result_word_t got);
            result_word_t want;
            if (due_words.size() == 0) begin
                errors++;
                $display("%0t: result word with none pending: kind %0d ack %0d tag %0d",
                         $time, got.kind, got.ack, got.tag);
                return;
            end
            want = due_words[0];
            due_words.delete(0);
            compare_field("kind", want.kind, got.kind);
            compare_field("ack_number", want.ack, got.ack);
            compare_field("out_tag", want.tag, got.tag);
            compare_field("out_size", want.size, got.size);
            compare_field("out_head", want.head, got.head);
            compare_field("out_tail", want.tail, got.tail);
            compare_field("last_result", want.last, got.last);
        endfunction
    endclass

    // Clock, reset and every block input start at known values.
    logic              aclk              = 1'b0;
    logic              aresetn           = 1'b0;
    logic              s_valid           = 1'b0;
    logic              s_checksum_ok     = 1'b0;
    logic [SEQ_W-1:0]  s_sequence_number = '0;
    logic              s_is_head         = 1'b0;
    logic              s_is_tail         = 1'b0;
    logic [SIZE_W-1:0] s_payload_size    = '0;
    logic [TAG_W-1:0]  s_payload_tag     = '0;
    logic              m_ready           = 1'b0;

    logic              s_ready;
    logic              m_valid;
    logic              m_kind;
    logic [SEQ_W-1:0]  m_ack_number;
    logic [TAG_W-1:0]  m_out_tag;
    logic [SIZE_W-1:0] m_out_size;
    logic              m_out_head;
    logic              m_out_tail;
    logic              m_last_result;

    window_scoreboard sb;
    bit               quiet         = 1'b0;
    int               headers_sent  = 0;
    int               cycle_count   = 0;
    int               ready_stall   = 0;
    result_word_t     seen_word;

    selective_repeat_receive_window DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_checksum_ok     (s_checksum_ok),
        .s_sequence_number (s_sequence_number),
        .s_is_head         (s_is_head),
        .s_is_tail         (s_is_tail),
        .s_payload_size    (s_payload_size),
        .s_payload_tag     (s_payload_tag),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kind            (m_kind),
        .m_ack_number      (m_ack_number),
        .m_out_tag         (m_out_tag),
        .m_out_size        (m_out_size),
        .m_out_head        (m_out_head),
        .m_out_tail        (m_out_tail),
        .m_last_result     (m_last_result)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: stall m_ready in random bursts; hold it high once quiet.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (quiet) begin
            m_ready <= 1'b1;
        end else if (ready_stall > 0) begin
            m_ready <= 1'b0;
            ready_stall--;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 7) == 0)
                ready_stall = $urandom_range(1, 17);
        end
    end

    // Check every word taken at this edge; values are the pre-edge ones.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_word.kind = m_kind;
            seen_word.ack  = m_ack_number;
            seen_word.tag  = m_out_tag;
            seen_word.size = m_out_size;
            seen_word.head = m_out_head;
            seen_word.tail = m_out_tail;
            seen_word.last = m_last_result;
            sb.check_word(seen_word);
        end
    end

    // Present one header word, hold it until taken, then note it and
    // maybe drop valid for a random burst.
    task automatic send_header(input logic ok, input logic [SEQ_W-1:0] seq,
                               input logic head, input logic tail,
                               input logic [SIZE_W-1:0] size,
                               input logic [TAG_W-1:0] tag);
        s_valid           <= 1'b1;
        s_checksum_ok     <= ok;
        s_sequence_number <= seq;
        s_is_head         <= head;
        s_is_tail         <= tail;
        s_payload_size    <= size;
        s_payload_tag     <= tag;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_header(ok, seq, head, tail, size, tag);
        headers_sent++;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17))
                @(posedge aclk);
        end
    endtask

    task automatic send_random(input logic ok, input logic [SEQ_W-1:0] seq);
        send_header(ok, seq, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    SIZE_W'($urandom_range(0, 127)), TAG_W'($urandom_range(0, 255)));
    endtask

    // Hold off the sender until every predicted word has been taken.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    initial begin
        int               directed_count;
        int               k;
        int               j;
        int               pick;
        logic [SEQ_W-1:0] base;
        logic [SEQ_W-1:0] tmp;
        logic [SEQ_W-1:0] order [$];

        sb = new();
        repeat (5)
            @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: bad checksum, then field extremes with the largest payload size.
        send_header(1'b0, 6'd0, 1'b1, 1'b1, 7'd127, 8'd255);
        send_header(1'b1, 6'd0, 1'b1, 1'b1, 7'd127, 8'd255);
        send_header(1'b1, 6'd1, 1'b0, 1'b0, 7'd0, 8'd0);
        // Park every slot but the expected one (cursor sits at slot 2).
        for (j = 3; j <= 9; j++)
            send_random(1'b1, SEQ_W'(j));
        // Duplicate, then a stale number that lands on a parked slot.
        send_header(1'b1, 6'd5, 1'b1, 1'b0, 7'd124, 8'hAA);
        send_random(1'b1, 6'd59);
        // Bad checksum on the expected slot must not release anything.
        send_random(1'b0, 6'd2);
        // Expected packet drains the whole window: longest result train.
        send_header(1'b1, 6'd2, 1'b0, 1'b1, 7'd64, 8'h55);
        // Far-ahead number mapping onto the expected slot is delivered.
        send_random(1'b1, 6'd42);
        // Top sequence number parked, released later by a short run.
        send_random(1'b1, 6'd63);
        send_random(1'b1, 6'd4);
        send_random(1'b1, 6'd3);
        send_random(1'b1, 6'd5);
        send_random(1'b1, 6'd6);
        wait_for_results();
        directed_count = headers_sent;

        // Random: mostly shuffled in-window bursts, some noise.
        while (headers_sent < directed_count + RANDOM_HEADERS) begin
            quiet = (headers_sent >= directed_count + RANDOM_HEADERS - QUIET_TAIL);
            if ($urandom_range(0, 9) < 8) begin
                k    = $urandom_range(1, WINDOW_SLOTS);
                base = SEQ_W'(sb.cursor + WINDOW_SLOTS * $urandom_range(0, 7));
                order.delete();
                for (j = 0; j < k; j++)
                    order.insert(order.size(), SEQ_W'(base + j));
                for (j = k - 1; j > 0; j--) begin
                    pick     = $urandom_range(0, j);
                    tmp      = order[j];
                    order[j] = order[pick];
                    order[pick] = tmp;
                end
                for (j = 0; j < k; j++) begin
                    if ($urandom_range(0, 9) == 0)
                        send_random(1'b0, order[j]);
                    send_random(1'b1, order[j]);
                    // Resend a packet that is still parked, maybe aliased.
                    if ($urandom_range(0, 7) == 0) begin
                        pick = $urandom_range(0, j);
                        if (sb.filled[order[pick] % WINDOW_SLOTS])
                            send_random(1'b1, SEQ_W'(order[pick]
                                        + WINDOW_SLOTS * $urandom_range(0, 7)));
                    end
                end
            end else begin
                repeat ($urandom_range(1, 3))
                    send_random(1'($urandom_range(0, 1)), SEQ_W'($urandom));
            end
            if ($urandom_range(0, 24) == 0)
                wait_for_results();
        end

        // Drain, then let the block settle before the verdict.
        wait_for_results();
        repeat (SETTLE_CYCLES)
            @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
